>>> rtl/core/ndstg_pkg.sv
`default_nettype none

package ndstg_pkg;

    localparam int PHASE_W = 18;
    localparam int SUM_W   = PHASE_W + 1;
    localparam int CNT_W   = $clog2(SUM_W);
    localparam int PITCH_W = 14;
    localparam int BASE_W  = 10;
    localparam int VOL_W   = 8;
    localparam int RATE_W  = 17;
    localparam int OCT_W   = 4;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    localparam int MAX_OCTAVE_DEF = 4;

    localparam logic [VOL_W-1:0]   VOLUME_RST      = 8'd255;
    localparam logic [RATE_W-1:0]  SAMPLE_RATE_RST = 17'd48000;
    localparam logic [PITCH_W-1:0] PITCH_RST       = 14'd262;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_NOTE = 1'b1;

    localparam logic REG_VOLUME      = 1'b0;
    localparam logic REG_SAMPLE_RATE = 1'b1;

    localparam logic [7:0] CH_C_LO  = 8'h43;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_C_HI  = 8'h63;
    localparam logic [7:0] CH_REST  = 8'h52;
    localparam logic [7:0] CH_UP    = 8'h3E;
    localparam logic [7:0] CH_DOWN  = 8'h3C;

    localparam logic [BASE_W-1:0] BASE_HZ [8] = '{
        10'd262, 10'd294, 10'd330, 10'd349, 10'd392, 10'd440, 10'd494, 10'd523
    };

    typedef struct packed {
        logic start;
        logic ack;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

>>> rtl/core/ndstg_phase_div.sv
`default_nettype none

module ndstg_phase_div (
    input  wire                                logic i_clk,
    input  wire                                logic i_rst_n,
    input  wire ndstg_pkg::t_div_req                 i_req,
    input  wire logic [ndstg_pkg::SUM_W-1:0]         i_sum,
    input  wire logic [ndstg_pkg::PHASE_W-1:0]       i_mod,
    output ndstg_pkg::t_div_stat                     o_stat,
    output logic [ndstg_pkg::PHASE_W-1:0]            o_rem
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_BUSY = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state                            r_state;
    t_state                            n_state;
    logic [ndstg_pkg::SUM_W-1:0]       r_rem;
    logic [ndstg_pkg::SUM_W-1:0]       n_rem;
    logic [ndstg_pkg::CNT_W-1:0]       r_cnt;
    logic [ndstg_pkg::CNT_W-1:0]       n_cnt;
    logic [ndstg_pkg::SUM_W-1:0]       w_mod_ext;
    logic                              w_ge;

    assign w_mod_ext = {1'b0, i_mod};
    assign w_ge      = (r_rem >> r_cnt) >= w_mod_ext;

    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.start) begin
                    n_rem   = i_sum;
                    n_cnt   = ndstg_pkg::CNT_W'(ndstg_pkg::SUM_W - 1);
                    n_state = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (w_ge) begin
                    n_rem = r_rem - (w_mod_ext << r_cnt);
                end
                if (r_cnt == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_DONE: begin
                if (i_req.ack) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_rem <= n_rem;
        r_cnt <= n_cnt;
    end

    assign o_stat.busy = (r_state != ST_IDLE);
    assign o_stat.done = (r_state == ST_DONE);
    assign o_rem       = r_rem[ndstg_pkg::PHASE_W-1:0];

endmodule

`default_nettype wire

>>> rtl/core/note_driven_square_tone_generator_unit.sv
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_ready  i_cmd, i_note_char
// output    out        o_valid / i_ready  o_sample, o_rewind
// config    in         psel / penable     paddr, pwrite, pwdata, prdata, pready
//
// One beat per cycle unless output stalls or a tick awaits the remainder unit; a beat
// is registered, then its result. A tick with phase or step not below twice a nonzero
// sample rate runs the bit-serial remainder unit, one quotient bit per cycle.
// Reset is synchronous and active low and restores the documented register values.
// A stalled result holds the next beat in the input register and then stops intake.
`default_nettype none

module note_driven_square_tone_generator_unit #(
    parameter int P_MAX_OCTAVE = ndstg_pkg::MAX_OCTAVE_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic                             i_cmd,
    input  wire logic [7:0]                       i_note_char,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic [ndstg_pkg::VOL_W-1:0]           o_sample,
    output logic                                  o_rewind,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [ndstg_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [ndstg_pkg::DATA_W-1:0]     pwdata,
    output logic [ndstg_pkg::DATA_W-1:0]          prdata,
    output logic                                  pready
);

    localparam logic signed [ndstg_pkg::OCT_W-1:0] L_OCT_MAX =
        ndstg_pkg::OCT_W'(P_MAX_OCTAVE);
    localparam logic signed [ndstg_pkg::OCT_W-1:0] L_OCT_MIN =
        ndstg_pkg::OCT_W'(-P_MAX_OCTAVE);
    localparam logic signed [ndstg_pkg::OCT_W-1:0] L_OCT_ONE =
        ndstg_pkg::OCT_W'(1);

    logic [ndstg_pkg::VOL_W-1:0]          r_volume;
    logic [ndstg_pkg::RATE_W-1:0]         r_rate;
    logic [ndstg_pkg::PHASE_W-1:0]        r_phase;
    logic [ndstg_pkg::PHASE_W-1:0]        n_phase;
    logic [ndstg_pkg::PITCH_W-1:0]        r_pitch;
    logic [ndstg_pkg::PITCH_W-1:0]        n_pitch;
    logic signed [ndstg_pkg::OCT_W-1:0]   r_oct;
    logic signed [ndstg_pkg::OCT_W-1:0]   n_oct;

    logic                                 r_in_valid;
    logic                                 r_cmd;
    logic [7:0]                           r_char;
    logic                                 r_out_valid;
    logic [ndstg_pkg::VOL_W-1:0]          r_sample;
    logic                                 r_rewind;
    logic [ndstg_pkg::VOL_W-1:0]          n_sample;
    logic                                 n_rewind;

    logic                                 w_cfg_wr;
    logic [ndstg_pkg::PHASE_W-1:0]        w_mod;
    logic [ndstg_pkg::PHASE_W-1:0]        w_step;
    logic [ndstg_pkg::SUM_W-1:0]          w_sum;
    logic [ndstg_pkg::SUM_W-1:0]          w_sum_red;
    logic                                 w_tick;
    logic                                 w_rate_zero;
    logic                                 w_fast;
    logic                                 w_need_div;
    logic                                 w_out_free;
    logic                                 w_advance;
    logic                                 w_letter;
    logic [2:0]                           w_idx;
    logic [ndstg_pkg::BASE_W-1:0]         w_base;
    logic [ndstg_pkg::OCT_W-1:0]          w_neg_oct;
    logic [ndstg_pkg::PITCH_W-1:0]        w_scaled;
    ndstg_pkg::t_div_req                  w_div_req;
    ndstg_pkg::t_div_stat                 w_div_stat;
    logic [ndstg_pkg::PHASE_W-1:0]        w_div_rem;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume <= ndstg_pkg::VOLUME_RST;
            r_rate   <= ndstg_pkg::SAMPLE_RATE_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                ndstg_pkg::REG_VOLUME:      r_volume <= pwdata[ndstg_pkg::VOL_W-1:0];
                ndstg_pkg::REG_SAMPLE_RATE: r_rate   <= pwdata[ndstg_pkg::RATE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            ndstg_pkg::REG_VOLUME:      prdata = ndstg_pkg::DATA_W'(r_volume);
            ndstg_pkg::REG_SAMPLE_RATE: prdata = ndstg_pkg::DATA_W'(r_rate);
            default:                    prdata = '0;
        endcase
    end

    assign w_tick      = r_in_valid && (r_cmd == ndstg_pkg::CMD_TICK);
    assign w_rate_zero = (r_rate == '0);
    assign w_mod       = {r_rate, 1'b0};
    assign w_step      = {3'b000, r_pitch, 1'b0};
    assign w_sum       = {1'b0, r_phase} + {1'b0, w_step};
    assign w_sum_red   = (w_sum >= {1'b0, w_mod}) ? (w_sum - {1'b0, w_mod}) : w_sum;
    assign w_fast      = (r_phase < w_mod) && (w_step < w_mod);
    assign w_need_div  = w_tick && !w_rate_zero && !w_fast;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_advance  = r_in_valid && w_out_free && (!w_need_div || w_div_stat.done);
    assign o_ready    = !r_in_valid || w_advance;

    assign w_div_req.start = w_need_div && !w_div_stat.busy;
    assign w_div_req.ack   = w_advance && w_need_div;

    ndstg_phase_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .i_sum   (w_sum),
        .i_mod   (w_mod),
        .o_stat  (w_div_stat),
        .o_rem   (w_div_rem)
    );

    always_comb begin
        w_letter = 1'b1;
        w_idx    = 3'd0;
        unique case (r_char)
            ndstg_pkg::CH_C_LO: w_idx = 3'd0;
            ndstg_pkg::CH_D:    w_idx = 3'd1;
            ndstg_pkg::CH_E:    w_idx = 3'd2;
            ndstg_pkg::CH_F:    w_idx = 3'd3;
            ndstg_pkg::CH_G:    w_idx = 3'd4;
            ndstg_pkg::CH_A:    w_idx = 3'd5;
            ndstg_pkg::CH_B:    w_idx = 3'd6;
            ndstg_pkg::CH_C_HI: w_idx = 3'd7;
            default:            w_letter = 1'b0;
        endcase
    end

    assign w_base    = ndstg_pkg::BASE_HZ[w_idx];
    assign w_neg_oct = -r_oct;
    assign w_scaled  = r_oct[ndstg_pkg::OCT_W-1]
        ? (ndstg_pkg::PITCH_W'(w_base) >> w_neg_oct[2:0])
        : (ndstg_pkg::PITCH_W'(w_base) << r_oct[2:0]);

    always_comb begin
        n_phase  = r_phase;
        n_pitch  = r_pitch;
        n_oct    = r_oct;
        n_sample = '0;
        n_rewind = 1'b0;
        if (w_tick) begin
            if (w_rate_zero) begin
                n_phase = '0;
            end else begin
                if (r_phase < {1'b0, r_rate}) begin
                    n_sample = r_volume;
                end
                n_phase = w_fast ? w_sum_red[ndstg_pkg::PHASE_W-1:0] : w_div_rem;
            end
        end else if (w_letter) begin
            n_pitch = w_scaled;
        end else begin
            unique case (r_char)
                ndstg_pkg::CH_REST: n_pitch = '0;
                ndstg_pkg::CH_UP: begin
                    if (r_oct < L_OCT_MAX) begin
                        n_oct = r_oct + L_OCT_ONE;
                    end
                end
                ndstg_pkg::CH_DOWN: begin
                    if (r_oct > L_OCT_MIN) begin
                        n_oct = r_oct - L_OCT_ONE;
                    end
                end
                default: n_rewind = 1'b1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= '0;
            r_pitch     <= ndstg_pkg::PITCH_RST;
            r_oct       <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
                r_pitch     <= n_pitch;
                r_oct       <= n_oct;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_ready && i_valid) begin
            r_cmd  <= i_cmd;
            r_char <= i_note_char;
        end
        if (w_advance) begin
            r_sample <= n_sample;
            r_rewind <= n_rewind;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_sample = r_sample;
    assign o_rewind = r_rewind;

    a_rewind_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rewind) |-> (o_sample == '0))
        else $error("rewind beat carries a nonzero sample");

    a_phase_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_tick && !w_rate_zero) |=> (r_phase < $past(w_mod)))
        else $error("phase left the modulus range after a tick");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.busy |-> (r_in_valid && (r_cmd == ndstg_pkg::CMD_TICK)))
        else $error("remainder unit busy without a pending tick");

    a_octave_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oct <= L_OCT_MAX) && (r_oct >= L_OCT_MIN))
        else $error("octave offset outside its limits");

endmodule

`default_nettype wire
